/* rtl/core/arpv_pkg.sv */
// ----------------------------------------------------------------------------
// ARP packet validator package
// Beat and result payloads, the captured header record, status codes and
// the fixed ARP constants shared by the front, queue and back modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpv_pkg;

  // Header and address geometry
  localparam int unsigned HDR_LEN        = 8;
  localparam int unsigned HW_ADDR_BYTES  = 6;
  localparam int unsigned PR_ADDR_BYTES  = 4;
  localparam logic [10:0] COUNT_MAX      = 11'h7FF;

  // Accepted hardware and protocol types
  localparam logic [15:0] HW_ETHER       = 16'h0001;
  localparam logic [15:0] HW_IEEE802     = 16'h0006;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETHER   = 8'd6;
  localparam logic [7:0]  PR_LEN_IPV4    = 8'd4;

  // Opcodes
  localparam logic [15:0] OP_REQUEST       = 16'd1;
  localparam logic [15:0] OP_REPLY         = 16'd2;
  localparam logic [15:0] OP_RARP_REQUEST  = 16'd3;
  localparam logic [15:0] OP_RARP_REPLY    = 16'd4;
  localparam logic [15:0] OP_INARP_REQUEST = 16'd8;
  localparam logic [15:0] OP_INARP_REPLY   = 16'd9;

  // Result status codes
  typedef enum logic [3:0] {
    ST_REQUEST       = 4'd0,
    ST_REPLY         = 4'd1,
    ST_TRUNCATED     = 4'd2,
    ST_BAD_HW_LEN    = 4'd3,
    ST_UNKNOWN_HW    = 4'd4,
    ST_BAD_PROTO_LEN = 4'd5,
    ST_UNKNOWN_PROTO = 4'd6,
    ST_MAC_MISMATCH  = 4'd7,
    ST_UNIMPL_OP     = 4'd8,
    ST_INVALID_OP    = 4'd9
  } arpv_status_t;

  // Input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic [47:0] frame_source_mac;
  } arpv_in_t;

  // Result beat
  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic        hw_addr_present;
  } arpv_out_t;

  // Fields captured from one payload
  typedef struct packed {
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_hw;
    logic [31:0] sender_proto;
    logic [47:0] target_hw;
    logic [31:0] target_proto;
  } arpv_cap_t;

  // One finished payload handed from front to back
  typedef struct packed {
    arpv_cap_t   cap;
    logic [11:0] len;
    logic [47:0] src_mac;
  } arpv_rec_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } arpv_qstat_t;

endpackage

/* rtl/core/arpv_ifs.sv */
// ----------------------------------------------------------------------------
// ARP packet validator stream interfaces
// Valid/ready channels for payload beats in and result beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arpv_in_if
  import arpv_pkg::*;
();
  logic     valid;
  logic     ready;
  arpv_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arpv_out_if
  import arpv_pkg::*;
();
  logic      valid;
  logic      ready;
  arpv_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/arpv_front.sv */
// ----------------------------------------------------------------------------
// ARP packet validator front end
// Accepts payload beats, tracks the byte position and captures the header
// and address fields; pushes one record per payload on its last beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpv_front
  import arpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  arpv_in_if.sink     pkt,
  input  arpv_qstat_t q_stat,
  output logic        push,
  output arpv_rec_t   rec
);

  logic [10:0] byte_count;
  arpv_cap_t   cap;
  arpv_cap_t   cap_next;
  logic        accept;

  // Address region boundaries, relative to the end of the header
  logic [10:0] off;
  logic [10:0] hw_end;
  logic [10:0] sp_end;
  logic [10:0] th_end;
  logic [10:0] tp_end;

  assign pkt.ready = !q_stat.full;
  assign accept    = pkt.valid && pkt.ready;
  assign push      = accept && pkt.data.last;

  assign off    = byte_count - 11'(HDR_LEN);
  assign hw_end = {3'b000, cap.hw_len};
  assign sp_end = hw_end + {3'b000, cap.proto_len};
  assign th_end = sp_end + {3'b000, cap.hw_len};
  assign tp_end = th_end + {3'b000, cap.proto_len};

  // Capture the current byte into its field
  always_comb begin
    cap_next = cap;
    if (byte_count < 11'(HDR_LEN)) begin
      case (byte_count[2:0])
        3'd0, 3'd1: cap_next.hw_type    = {cap.hw_type[7:0], pkt.data.data_byte};
        3'd2, 3'd3: cap_next.proto_type = {cap.proto_type[7:0], pkt.data.data_byte};
        3'd4:       cap_next.hw_len     = pkt.data.data_byte;
        3'd5:       cap_next.proto_len  = pkt.data.data_byte;
        default:    cap_next.opcode     = {cap.opcode[7:0], pkt.data.data_byte};
      endcase
    end else if (off < hw_end) begin
      if (off < 11'(HW_ADDR_BYTES)) begin
        cap_next.sender_hw = {cap.sender_hw[39:0], pkt.data.data_byte};
      end
    end else if (off < sp_end) begin
      if ((off - hw_end) < 11'(PR_ADDR_BYTES)) begin
        cap_next.sender_proto = {cap.sender_proto[23:0], pkt.data.data_byte};
      end
    end else if (off < th_end) begin
      if ((off - sp_end) < 11'(HW_ADDR_BYTES)) begin
        cap_next.target_hw = {cap.target_hw[39:0], pkt.data.data_byte};
      end
    end else if (off < tp_end) begin
      if ((off - th_end) < 11'(PR_ADDR_BYTES)) begin
        cap_next.target_proto = {cap.target_proto[23:0], pkt.data.data_byte};
      end
    end
  end

  // Build the record for the queue
  assign rec.cap     = cap_next;
  assign rec.len     = {1'b0, byte_count} + 12'd1;
  assign rec.src_mac = pkt.data.frame_source_mac;

  // Advance position and fields; clear after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      cap        <= '0;
    end else if (accept) begin
      if (pkt.data.last) begin
        byte_count <= '0;
        cap        <= '0;
      end else begin
        cap <= cap_next;
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 11'd1;
        end
      end
    end
  end

endmodule

/* rtl/core/arpv_queue.sv */
// ----------------------------------------------------------------------------
// ARP packet validator record queue
// Small FIFO of finished payload records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpv_queue
  import arpv_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  arpv_rec_t   wr_rec,
  input  logic        pop,
  output arpv_rec_t   head,
  output arpv_qstat_t q_stat
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  arpv_rec_t         slots [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign head         = slots[rd_ptr];

  // Store a record on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/arpv_back.sv */
// ----------------------------------------------------------------------------
// ARP packet validator back end
// Classifies the record at the queue head and holds the result beat in an
// output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpv_back
  import arpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  arpv_qstat_t q_stat,
  input  arpv_rec_t   head,
  output logic        pop,
  arpv_out_if.source  result
);

  arpv_status_t status;
  arpv_out_t    res_next;
  logic [11:0]  len_need;
  logic         truncated;
  logic         hw_ok;
  logic         pr_ok;

  assign pop = !q_stat.empty && (!result.valid || result.ready);

  // Length the two address lengths call for
  assign len_need  = 12'(HDR_LEN) + {3'b000, head.cap.hw_len, 1'b0}
                   + {3'b000, head.cap.proto_len, 1'b0};
  assign truncated = (head.len < 12'(HDR_LEN)) || (head.len < len_need);
  assign hw_ok     = head.cap.hw_len >= 8'(HW_ADDR_BYTES);
  assign pr_ok     = head.cap.proto_len >= 8'(PR_ADDR_BYTES);

  // Run the checks in priority order
  always_comb begin
    if (truncated) begin
      status = ST_TRUNCATED;
    end else if (!(head.cap.hw_type == HW_ETHER || head.cap.hw_type == HW_IEEE802)) begin
      status = ST_UNKNOWN_HW;
    end else if (head.cap.hw_len != HW_LEN_ETHER) begin
      status = ST_BAD_HW_LEN;
    end else if (head.cap.proto_type != PROTO_IPV4) begin
      status = ST_UNKNOWN_PROTO;
    end else if (head.cap.proto_len != PR_LEN_IPV4) begin
      status = ST_BAD_PROTO_LEN;
    end else if (head.cap.sender_hw != head.src_mac) begin
      status = ST_MAC_MISMATCH;
    end else begin
      case (head.cap.opcode)
        OP_REQUEST: status = ST_REQUEST;
        OP_REPLY:   status = ST_REPLY;
        OP_RARP_REQUEST, OP_RARP_REPLY,
        OP_INARP_REQUEST, OP_INARP_REPLY: status = ST_UNIMPL_OP;
        default:    status = ST_INVALID_OP;
      endcase
    end
  end

  // Mask short address fields; zero everything on truncation
  always_comb begin
    res_next.status = status;
    if (truncated) begin
      res_next.sender_ip       = '0;
      res_next.sender_mac      = '0;
      res_next.target_ip       = '0;
      res_next.target_mac      = '0;
      res_next.hw_addr_present = 1'b0;
    end else begin
      res_next.sender_ip       = pr_ok ? head.cap.sender_proto : '0;
      res_next.sender_mac      = hw_ok ? head.cap.sender_hw : '0;
      res_next.target_ip       = pr_ok ? head.cap.target_proto : '0;
      res_next.target_mac      = hw_ok ? head.cap.target_hw : '0;
      res_next.hw_addr_present = hw_ok;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.data <= res_next;
    end
  end

endmodule

/* rtl/core/arp_packet_validator.sv */
// ----------------------------------------------------------------------------
// ARP packet validator
// Parses an ARP payload a byte per beat and gives one status and address
// result per payload.
//
//   channel  dir  handshake            payload
//   pkt      in   pkt.valid/ready      data_byte, last, frame_source_mac
//   result   out  result.valid/ready   status, sender/target ip and mac,
//                                      hw_addr_present
//
// One byte beat is taken per cycle unless the record queue is full; the front captures fields as bytes pass.
// A result passes from its last beat through a record queue and
// the output register in the back end.
// pkt.ready drops only while the record queue is full; result stalls fill it.
// Reset is synchronous and clears the byte position, fields and queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_packet_validator
  import arpv_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  arpv_in_if.sink    pkt,
  arpv_out_if.source result
);

  arpv_qstat_t q_stat;
  arpv_rec_t   rec_in;
  arpv_rec_t   rec_head;
  logic        push;
  logic        pop;

  arpv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pkt    (pkt),
    .q_stat (q_stat),
    .push   (push),
    .rec    (rec_in)
  );

  arpv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (rec_in),
    .pop    (pop),
    .head   (rec_head),
    .q_stat (q_stat)
  );

  arpv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (rec_head),
    .pop    (pop),
    .result (result)
  );

  // Queue cannot be empty and full at once
  assert property (@(posedge clk) disable iff (rst) !(q_stat.empty && q_stat.full))
    else $error("record queue empty and full together");

  // A last beat leaves a record waiting in the queue
  assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready && pkt.data.last) |=> !q_stat.empty)
    else $error("last beat did not reach the record queue");

  // Status stays within the defined codes
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.status <= ST_INVALID_OP))
    else $error("result status out of range");

  // No pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("pop from empty record queue");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// ARP packet validator testbench
// Streams ARP payloads byte by byte into the validator, predicts the status
// and address fields of each payload on the fly, and checks every result
// beat in order. Directed payloads cover each status class and the address
// length extremes. Random payloads follow, mostly well-formed with random
// content. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import arpv_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 820;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [7:0] payload_t[$];

  // Running ARP parse state and the queue of verdicts still owed by the block
  class arp_verdict_board;
    logic [10:0] count;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [15:0] oper;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [47:0] sha;
    logic [47:0] tha;
    logic [31:0] spa;
    logic [31:0] tpa;
    arpv_out_t   pending_verdicts[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      count = '0;
      htype = '0;
      ptype = '0;
      oper  = '0;
      hlen  = '0;
      plen  = '0;
      sha   = '0;
      tha   = '0;
      spa   = '0;
      tpa   = '0;
    endfunction

    function arpv_status_t status_for(int len, logic [47:0] src);
      int h;
      int p;
      h = int'(hlen);
      p = int'(plen);
      if (len < HDR_LEN || len < HDR_LEN + 2 * h + 2 * p) return ST_TRUNCATED;
      if (htype == HW_ETHER || htype == HW_IEEE802) begin
        if (hlen != HW_LEN_ETHER) return ST_BAD_HW_LEN;
      end else begin
        return ST_UNKNOWN_HW;
      end
      if (ptype == PROTO_IPV4) begin
        if (plen != PR_LEN_IPV4) return ST_BAD_PROTO_LEN;
      end else begin
        return ST_UNKNOWN_PROTO;
      end
      if (sha != src) return ST_MAC_MISMATCH;
      case (oper)
        OP_REQUEST: return ST_REQUEST;
        OP_REPLY:   return ST_REPLY;
        OP_RARP_REQUEST, OP_RARP_REPLY, OP_INARP_REQUEST, OP_INARP_REPLY:
          return ST_UNIMPL_OP;
        default:    return ST_INVALID_OP;
      endcase
    endfunction

    // Capture one accepted byte; queue a verdict on the last beat
    function void take_byte(arpv_in_t beat);
      int          off;
      int          h;
      int          p;
      int          len;
      logic [7:0]  b;
      arpv_out_t   verdict;
      b = beat.data_byte;
      if (count < HDR_LEN) begin
        case (count[2:0])
          3'd0, 3'd1: htype = {htype[7:0], b};
          3'd2, 3'd3: ptype = {ptype[7:0], b};
          3'd4:       hlen  = b;
          3'd5:       plen  = b;
          default:    oper  = {oper[7:0], b};
        endcase
      end else begin
        off = int'(count) - int'(HDR_LEN);
        h   = int'(hlen);
        p   = int'(plen);
        if (off < h) begin
          if (off < HW_ADDR_BYTES) sha = {sha[39:0], b};
        end else if (off < h + p) begin
          if (off - h < PR_ADDR_BYTES) spa = {spa[23:0], b};
        end else if (off < 2 * h + p) begin
          if (off - h - p < HW_ADDR_BYTES) tha = {tha[39:0], b};
        end else if (off < 2 * h + 2 * p) begin
          if (off - 2 * h - p < PR_ADDR_BYTES) tpa = {tpa[23:0], b};
        end
      end
      len = int'(count) + 1;
      if (count != COUNT_MAX) count = count + 11'd1;
      if (!beat.last) return;

      verdict = '0;
      verdict.status = status_for(len, beat.frame_source_mac);
      if (verdict.status != ST_TRUNCATED) begin
        if (plen >= PR_ADDR_BYTES) begin
          verdict.sender_ip = spa;
          verdict.target_ip = tpa;
        end
        if (hlen >= HW_ADDR_BYTES) begin
          verdict.sender_mac      = sha;
          verdict.target_mac      = tha;
          verdict.hw_addr_present = 1'b1;
        end
      end
      pending_verdicts.push_back(verdict);
      clear();
    endfunction

    function void compare(string field, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Check one result beat against the oldest owed verdict
    function void match_result(arpv_out_t got);
      arpv_out_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, expected nothing, actual status %0h",
                 $time, got.status);
        return;
      end
      want = pending_verdicts.pop_front();
      compare("status", 48'(want.status), 48'(got.status));
      compare("sender_ip", 48'(want.sender_ip), 48'(got.sender_ip));
      compare("sender_mac", want.sender_mac, got.sender_mac);
      compare("target_ip", 48'(want.target_ip), 48'(got.target_ip));
      compare("target_mac", want.target_mac, got.target_mac);
      compare("hw_addr_present", 48'(want.hw_addr_present), 48'(got.hw_addr_present));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;
  int   cycles = 0;

  arp_verdict_board board = new();

  arpv_in_if  pkt_if ();
  arpv_out_if res_if ();

  arp_packet_validator i_dut (
    .clk    (clk),
    .rst    (rst),
    .pkt    (pkt_if),
    .result (res_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side at random, with a chance of about 23 in a hundred, except while quiet
  always @(posedge clk) begin
    res_if.ready <= quiet || ($urandom_range(99) >= 23);
  end

  // Watch both channels: note accepted bytes, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (pkt_if.valid && pkt_if.ready) board.take_byte(pkt_if.data);
      if (res_if.valid && res_if.ready) board.match_result(res_if.data);
    end
  end

  function automatic logic [47:0] rand_mac();
    logic [47:0] m;
    m[47:16] = $urandom;
    m[15:0]  = 16'($urandom);
    return m;
  endfunction

  function automatic logic [15:0] pick_opcode();
    case ($urandom_range(7))
      0:       return OP_REQUEST;
      1:       return OP_REPLY;
      2:       return OP_RARP_REQUEST;
      3:       return OP_RARP_REPLY;
      4:       return OP_INARP_REQUEST;
      5:       return OP_INARP_REPLY;
      6:       return 16'($urandom_range(16'hFFFF));
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  // Lay out header, address fields and trailing bytes
  function automatic payload_t build_arp(logic [15:0] htype, logic [15:0] ptype,
                                         logic [7:0] hlen, logic [7:0] plen,
                                         logic [15:0] oper, logic [47:0] sha,
                                         logic [31:0] spa, logic [47:0] tha,
                                         logic [31:0] tpa, int extra);
    payload_t pl;
    pl = {};
    pl.push_back(htype[15:8]);
    pl.push_back(htype[7:0]);
    pl.push_back(ptype[15:8]);
    pl.push_back(ptype[7:0]);
    pl.push_back(hlen);
    pl.push_back(plen);
    pl.push_back(oper[15:8]);
    pl.push_back(oper[7:0]);
    for (int k = 0; k < hlen; k++)
      pl.push_back(k < 6 ? sha[47 - 8 * k -: 8] : 8'($urandom_range(255)));
    for (int k = 0; k < plen; k++)
      pl.push_back(k < 4 ? spa[31 - 8 * k -: 8] : 8'($urandom_range(255)));
    for (int k = 0; k < hlen; k++)
      pl.push_back(k < 6 ? tha[47 - 8 * k -: 8] : 8'($urandom_range(255)));
    for (int k = 0; k < plen; k++)
      pl.push_back(k < 4 ? tpa[31 - 8 * k -: 8] : 8'($urandom_range(255)));
    repeat (extra) pl.push_back(8'($urandom_range(255)));
    return pl;
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(arpv_in_t beat);
    while (!quiet && $urandom_range(99) < 23) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_if.valid <= 1'b1;
    pkt_if.data  <= beat;
    do @(posedge clk); while (!pkt_if.ready);
  endtask

  // Stream one payload; the source MAC only matters on the last beat
  task automatic send_payload(payload_t pl, logic [47:0] src);
    arpv_in_t beat;
    for (int i = 0; i < pl.size(); i++) begin
      beat.data_byte        = pl[i];
      beat.last             = (i == pl.size() - 1);
      beat.frame_source_mac = beat.last ? src : rand_mac();
      send_beat(beat);
    end
  endtask

  task automatic trim(ref payload_t pl, input int keep);
    while (pl.size() > keep) void'(pl.pop_back());
  endtask

  initial begin
    payload_t    pl;
    logic [47:0] m;
    logic [47:0] src;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [15:0] oper;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] ops[8];
    int          sent;
    int          idx;
    int          kind;
    int          extra;

    pkt_if.valid = 1'b0;
    pkt_if.data  = '0;
    res_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: each status class and the field extremes
    m = 48'h0200_1234_5678;
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, OP_REQUEST,
                           m, 32'hC0A8_0001, 48'h0, 32'hC0A8_00FE, 0), m);
    m = '1;
    send_payload(build_arp(HW_IEEE802, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, OP_REPLY,
                           m, '1, '1, '1, 3), m);
    m = '0;
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, OP_REQUEST,
                           m, '0, '0, '0, 0), m);
    ops = '{OP_RARP_REQUEST, OP_RARP_REPLY, OP_INARP_REQUEST, OP_INARP_REPLY,
            16'h0000, 16'hFFFF, 16'h0005, 16'h0100};
    foreach (ops[i]) begin
      m = rand_mac();
      send_payload(build_arp(HW_ETHER, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, ops[i],
                             m, $urandom, rand_mac(), $urandom, 0), m);
    end
    m = rand_mac();
    send_payload(build_arp(16'hFFFF, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m);
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, 8'd5, PR_LEN_IPV4, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m);
    send_payload(build_arp(HW_IEEE802, PROTO_IPV4, 8'd7, PR_LEN_IPV4, OP_REPLY,
                           m, $urandom, rand_mac(), $urandom, 0), m);
    send_payload(build_arp(HW_ETHER, 16'h86DD, HW_LEN_ETHER, PR_LEN_IPV4, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m);
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, HW_LEN_ETHER, 8'd16, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m);
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m ^ 48'h1);
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, 8'd0, 8'd0, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m);

    // Truncated: one byte, short header, body one byte short
    pl = build_arp(HW_ETHER, PROTO_IPV4, HW_LEN_ETHER, PR_LEN_IPV4, OP_REQUEST,
                   m, $urandom, rand_mac(), $urandom, 0);
    trim(pl, pl.size() - 1);
    send_payload(pl, m);
    trim(pl, 7);
    send_payload(pl, m);
    trim(pl, 1);
    send_payload(pl, m);

    // Long address fields complete; largest address lengths cut short
    send_payload(build_arp(HW_ETHER, PROTO_IPV4, 8'd40, 8'd24, OP_REQUEST,
                           m, $urandom, rand_mac(), $urandom, 0), m);
    pl = build_arp(HW_ETHER, PROTO_IPV4, 8'hFF, 8'hFF, OP_REQUEST,
                   m, $urandom, rand_mac(), $urandom, 0);
    trim(pl, 100);
    send_payload(pl, m);

    // Random: mostly well-formed, some bent headers, cuts and noise
    sent = 0;
    idx  = 0;
    while (sent < RANDOM_BYTES) begin
      quiet = (idx >= 10 && idx < 25);
      m     = rand_mac();
      src   = m;
      htype = $urandom_range(1) ? HW_ETHER : HW_IEEE802;
      ptype = PROTO_IPV4;
      hlen  = HW_LEN_ETHER;
      plen  = PR_LEN_IPV4;
      oper  = pick_opcode();
      extra = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
      kind  = $urandom_range(99);
      if (kind < 70) begin
        if ($urandom_range(19) == 0) src = m ^ (48'h1 << $urandom_range(47));
      end else if (kind < 85) begin
        case ($urandom_range(4))
          0:       htype = 16'($urandom_range(16'hFFFF));
          1:       hlen  = 8'($urandom_range(12));
          2:       ptype = 16'($urandom_range(16'hFFFF));
          3:       plen  = 8'($urandom_range(10));
          default: src   = rand_mac();
        endcase
      end
      pl = build_arp(htype, ptype, hlen, plen, oper, m, $urandom, rand_mac(), $urandom,
                     extra);
      if (kind >= 85 && kind < 95) begin
        trim(pl, $urandom_range(1, pl.size() - 1));
      end else if (kind >= 95) begin
        pl = {};
        repeat ($urandom_range(1, 40)) pl.push_back(8'($urandom_range(255)));
      end
      send_payload(pl, src);
      sent += pl.size();
      idx++;
    end
    pkt_if.valid <= 1'b0;
    quiet = 1'b0;

    // Drain outstanding verdicts, then watch for strays
    @(posedge clk);
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/arpv_pkg.sv
rtl/core/arpv_ifs.sv
rtl/core/arpv_front.sv
rtl/core/arpv_queue.sv
rtl/core/arpv_back.sv
rtl/core/arp_packet_validator.sv
bench/testbench.sv
